// File: sv/regular_polygon_vertex_generator_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion helpers for the polygon vertex generator
// Each macro expands to one labeled concurrent assertion on the rising clock.
// ---------------------------------------------------------------------------
`ifndef REGULAR_POLYGON_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define REGULAR_POLYGON_VERTEX_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPVG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/rpvg_pkg.sv
// ---------------------------------------------------------------------------
// rpvg_pkg
// Shared types, constants and helper functions of the polygon vertex generator.
// ---------------------------------------------------------------------------
package rpvg_pkg;

   localparam int MAX_EDGES = 63;
   localparam int MIN_EDGES = 3;
   localparam int EDGE_W    = 6;
   localparam int RADIUS_W  = 23;
   localparam int COORD_W   = 24;
   localparam int ANGLE_W   = 9;
   localparam int KIND_W    = 2;

   localparam logic [ANGLE_W-1:0] DEG_FULL = 9'd360;
   localparam int HALF_DEG_FULL = 180;

   localparam logic [KIND_W-1:0] KIND_MOVE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ELLIPSE = 2'd2;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Phase divider: numerator is up to 249 or 359 turns-times-2^32.
   localparam int PHASE_W   = 32;
   localparam int DIV_NUM_W = 41;
   localparam int DIV_DEN_W = 9;
   localparam int DIV_REM_W = 10;
   localparam int DIV_CNT_W = 6;

   // Sine and cosine.
   localparam int TRIG_W      = 16;
   localparam int Q30_W       = 30;
   localparam int T_W         = 31;
   localparam int RECIP_W     = 32;
   localparam int STEP_W      = 3;
   localparam logic [T_W-1:0]     ONE_Q30 = 31'h4000_0000;
   localparam logic [PHASE_W-1:0] PI_Q30  = 32'd3373259426;
   localparam logic [STEP_W-1:0]  SIN_LAST_STEP  = 3'd2;
   localparam logic [STEP_W-1:0]  COS_FIRST_STEP = 3'd3;
   localparam logic [STEP_W-1:0]  COS_LAST_STEP  = 3'd6;

   // Vertex arithmetic.
   localparam int PROD_W = 42;
   localparam int PT_W   = 25;
   localparam int SUM_W  = 27;

   typedef struct packed {
      logic                        is_circle;
      logic [EDGE_W-1:0]           edge_count;
      logic [RADIUS_W-1:0]         radius;
      logic signed [COORD_W-1:0]   center_x;
      logic signed [COORD_W-1:0]   center_y;
      logic [ANGLE_W-1:0]          angle_deg;
   } req_word_type;

   typedef struct packed {
      logic [KIND_W-1:0]           point_kind;
      logic signed [COORD_W-1:0]   point_x;
      logic signed [COORD_W-1:0]   point_y;
      logic [RADIUS_W-1:0]         ellipse_radius;
      logic                        last;
   } rsp_word_type;

   typedef struct packed {
      logic                        start;
      logic [DIV_NUM_W-1:0]        num;
      logic [DIV_DEN_W-1:0]        den;
   } div_req_type;

   typedef struct packed {
      logic                        done;
      logic [PHASE_W-1:0]          quot;
   } div_rsp_type;

   typedef struct packed {
      logic                        start;
      logic [PHASE_W-1:0]          phase;
   } trig_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [TRIG_W-1:0]    sin_val;
      logic signed [TRIG_W-1:0]    cos_val;
   } trig_rsp_type;

   // Divisors of the nested Taylor terms: sine chain first, then cosine.
   function automatic logic [5:0] trig_divisor(input logic [STEP_W-1:0] step);
      case (step)
         3'd0:    trig_divisor = 6'd42;
         3'd1:    trig_divisor = 6'd20;
         3'd2:    trig_divisor = 6'd6;
         3'd3:    trig_divisor = 6'd56;
         3'd4:    trig_divisor = 6'd30;
         3'd5:    trig_divisor = 6'd12;
         3'd6:    trig_divisor = 6'd2;
         default: trig_divisor = 6'd2;
      endcase
   endfunction

   // floor(2^32 / divisor); the estimate is at most one below the true quotient.
   function automatic logic [RECIP_W-1:0] trig_recip(input logic [STEP_W-1:0] step);
      case (step)
         3'd0:    trig_recip = 32'd102261126;
         3'd1:    trig_recip = 32'd214748364;
         3'd2:    trig_recip = 32'd715827882;
         3'd3:    trig_recip = 32'd76695844;
         3'd4:    trig_recip = 32'd143165576;
         3'd5:    trig_recip = 32'd357913941;
         3'd6:    trig_recip = 32'd2147483648;
         default: trig_recip = 32'd2147483648;
      endcase
   endfunction

   function automatic logic [TRIG_W-1:0] q30_to_q15(input logic [T_W-1:0] v);
      logic [T_W-1:0] r;
      r = (v + T_W'(16384)) >> 15;
      q30_to_q15 = (r > T_W'(32767)) ? TRIG_W'(32767) : r[TRIG_W-1:0];
   endfunction

   // Divide by 2^15, rounding to nearest with ties away from zero.
   function automatic logic signed [PROD_W-1:0] round_q15(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] q;
      mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
      q = (mag + PROD_W'(16384)) >> 15;
      round_q15 = v[PROD_W-1] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      if (v > $signed(SUM_W'(8388607))) begin
         sat_coord = COORD_W'(8388607);
      end else if (v < -$signed(SUM_W'(8388608))) begin
         sat_coord = COORD_W'(8388608);
      end else begin
         sat_coord = v[COORD_W-1:0];
      end
   endfunction

endpackage

// File: sv/rpvg_front.sv
// ---------------------------------------------------------------------------
// rpvg_front
// Accepts figures, clamps the edge count, folds the angle and queues them.
// ---------------------------------------------------------------------------
module rpvg_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  rpvg_pkg::req_word_type req_data,
   output logic                  cmd_valid,
   input  logic                  cmd_pop,
   output rpvg_pkg::req_word_type cmd_data
);
   import rpvg_pkg::*;

   req_word_type            clean;
   req_word_type            queue_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;
   logic                    do_push, do_pop;

   always_comb begin
      clean = req_data;
      if (req_data.edge_count < EDGE_W'(MIN_EDGES)) begin
         clean.edge_count = EDGE_W'(MIN_EDGES);
      end else if (req_data.edge_count > EDGE_W'(MAX_EDGES)) begin
         clean.edge_count = EDGE_W'(MAX_EDGES);
      end
      if (req_data.angle_deg >= DEG_FULL) begin
         clean.angle_deg = req_data.angle_deg - DEG_FULL;
      end
   end

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = queue_mem[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_mem[wr_ptr_ff] <= clean;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/rpvg_div.sv
// ---------------------------------------------------------------------------
// rpvg_div
// Restoring divider, one quotient bit per cycle, for corner and angle phases.
// ---------------------------------------------------------------------------
module rpvg_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rpvg_pkg::div_req_type div_req,
   output rpvg_pkg::div_rsp_type div_rsp
);
   import rpvg_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0]    num_ff, num_in;
   logic [DIV_DEN_W-1:0]    den_ff, den_in;
   logic [DIV_REM_W-1:0]    rem_ff, rem_in;
   logic [PHASE_W-1:0]      quot_ff, quot_in;
   logic [DIV_REM_W-1:0]    rem_sh;
   logic                    take;

   always_comb begin
      rem_sh   = {rem_ff[DIV_REM_W-2:0], num_ff[DIV_NUM_W-1]};
      take     = (rem_sh >= {1'b0, den_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         num_in  = num_ff << 1;
         rem_in  = take ? rem_sh - {1'b0, den_ff} : rem_sh;
         quot_in = {quot_ff[PHASE_W-2:0], take};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// File: sv/rpvg_trig.sv
// ---------------------------------------------------------------------------
// rpvg_trig
// Sequenced sine and cosine of a 32-bit turn fraction by octant polynomials.
// ---------------------------------------------------------------------------
module rpvg_trig (
   input  logic                  clock,
   input  logic                  reset,
   input  rpvg_pkg::trig_req_type trig_req,
   output rpvg_pkg::trig_rsp_type trig_rsp
);
   import rpvg_pkg::*;

   localparam logic [2:0] T_IDLE = 3'd0;
   localparam logic [2:0] T_X    = 3'd1;
   localparam logic [2:0] T_X2   = 3'd2;
   localparam logic [2:0] T_A    = 3'd3;
   localparam logic [2:0] T_Q    = 3'd4;
   localparam logic [2:0] T_C    = 3'd5;
   localparam logic [2:0] T_S    = 3'd6;
   localparam logic [2:0] T_R    = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic                    done_ff, done_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [1:0]              quad_ff, quad_in;
   logic                    swap_ff, swap_in;
   logic [Q30_W-1:0]        arg_ff, arg_in;
   logic [Q30_W-1:0]        x_ff, x_in;
   logic [Q30_W-1:0]        x2_ff, x2_in;
   logic [T_W-1:0]          t_ff, t_in;
   logic [Q30_W-1:0]        a_ff, a_in;
   logic [Q30_W-1:0]        q0_ff, q0_in;
   logic [T_W-1:0]          sv_ff, sv_in;
   logic signed [TRIG_W-1:0] sin_ff, sin_in;
   logic signed [TRIG_W-1:0] cos_ff, cos_in;

   logic [Q30_W-1:0]        w;
   logic [62:0]             xprod;
   logic [59:0]             sq;
   logic [60:0]             at;
   logic [61:0]             qe;
   logic [35:0]             qd;
   logic [35:0]             rem;
   logic [Q30_W-1:0]        q;
   logic [TRIG_W-1:0]       sa_u, ca_u;
   logic signed [TRIG_W-1:0] sa, ca;

   always_comb begin
      w     = trig_req.phase[Q30_W-1:0];
      xprod = 63'(arg_ff) * 63'(PI_Q30) + 63'(ONE_Q30);
      sq    = 60'(x_ff) * 60'(x_ff);
      at    = 61'(state_ff == T_S ? x_ff : x2_ff) * 61'(t_ff);
      qe    = 62'(a_ff) * 62'(trig_recip(step_ff));
      qd    = 36'(q0_ff) * 36'(trig_divisor(step_ff));
      rem   = 36'(a_ff) - qd;
      q     = q0_ff + Q30_W'(rem >= 36'(trig_divisor(step_ff)));
      sa_u  = swap_ff ? q30_to_q15(t_ff) : q30_to_q15(sv_ff);
      ca_u  = swap_ff ? q30_to_q15(sv_ff) : q30_to_q15(t_ff);
      sa    = $signed(sa_u);
      ca    = $signed(ca_u);

      state_in = state_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      quad_in  = quad_ff;
      swap_in  = swap_ff;
      arg_in   = arg_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      t_in     = t_ff;
      a_in     = a_ff;
      q0_in    = q0_ff;
      sv_in    = sv_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;

      case (state_ff)
         T_IDLE: begin
            if (trig_req.start) begin
               quad_in  = trig_req.phase[PHASE_W-1:PHASE_W-2];
               swap_in  = w[Q30_W-1];
               // Upper half of the quadrant mirrors onto the lower octant.
               arg_in   = w[Q30_W-1] ? (Q30_W'(1) << (Q30_W - 1)) - (w - (Q30_W'(1) << (Q30_W - 1)))
                                     : w;
               state_in = T_X;
            end
         end
         T_X: begin
            x_in     = xprod[60:31];
            state_in = T_X2;
         end
         T_X2: begin
            x2_in    = sq[59:30];
            t_in     = ONE_Q30;
            step_in  = '0;
            state_in = T_A;
         end
         T_A: begin
            a_in     = at[59:30];
            state_in = T_Q;
         end
         T_Q: begin
            q0_in    = qe[61:32];
            state_in = T_C;
         end
         T_C: begin
            t_in = ONE_Q30 - T_W'(q);
            if (step_ff == SIN_LAST_STEP) begin
               state_in = T_S;
            end else if (step_ff == COS_LAST_STEP) begin
               state_in = T_R;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = T_A;
            end
         end
         T_S: begin
            sv_in    = at[60:30];
            t_in     = ONE_Q30;
            step_in  = COS_FIRST_STEP;
            state_in = T_A;
         end
         T_R: begin
            case (quad_ff)
               2'd0: begin sin_in = sa;  cos_in = ca;  end
               2'd1: begin sin_in = ca;  cos_in = -sa; end
               2'd2: begin sin_in = -sa; cos_in = -ca; end
               default: begin sin_in = -ca; cos_in = sa; end
            endcase
            done_in  = 1'b1;
            state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   assign trig_rsp.done    = done_ff;
   assign trig_rsp.sin_val = sin_ff;
   assign trig_rsp.cos_val = cos_ff;

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quad_ff <= quad_in;
      swap_ff <= swap_in;
      arg_ff  <= arg_in;
      x_ff    <= x_in;
      x2_ff   <= x2_in;
      t_ff    <= t_in;
      a_ff    <= a_in;
      q0_ff   <= q0_in;
      sv_ff   <= sv_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
      if (reset) begin
         state_ff <= T_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

endmodule

// File: sv/rpvg_back.sv
// ---------------------------------------------------------------------------
// rpvg_back
// Walks the corners of a queued figure and produces its result words.
// ---------------------------------------------------------------------------
module rpvg_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  rpvg_pkg::req_word_type  cmd_data,
   output rpvg_pkg::div_req_type   div_req,
   input  rpvg_pkg::div_rsp_type   div_rsp,
   output rpvg_pkg::trig_req_type  trig_req,
   input  rpvg_pkg::trig_rsp_type  trig_rsp,
   output logic                   empty,
   input  logic                   pop,
   output rpvg_pkg::rsp_word_type  rsp_data
);
   import rpvg_pkg::*;

   localparam logic [3:0] B_IDLE = 4'd0;
   localparam logic [3:0] B_AS   = 4'd1;
   localparam logic [3:0] B_DANG = 4'd2;
   localparam logic [3:0] B_TANG = 4'd3;
   localparam logic [3:0] B_DS   = 4'd4;
   localparam logic [3:0] B_DV   = 4'd5;
   localparam logic [3:0] B_TV   = 4'd6;
   localparam logic [3:0] B_M1   = 4'd7;
   localparam logic [3:0] B_M2   = 4'd8;
   localparam logic [3:0] B_M3   = 4'd9;
   localparam logic [3:0] B_M4   = 4'd10;
   localparam logic [3:0] B_M5   = 4'd11;
   localparam logic [3:0] B_M6   = 4'd12;
   localparam logic [3:0] B_M7   = 4'd13;
   localparam logic [3:0] B_FIN  = 4'd14;
   localparam logic [3:0] B_OUT  = 4'd15;

   logic [3:0]               state_ff, state_in;
   req_word_type             cmd_ff, cmd_in;
   logic [EDGE_W-1:0]        k_ff, k_in;
   logic signed [TRIG_W-1:0] sa_ff, sa_in, ca_ff, ca_in;
   logic signed [TRIG_W-1:0] ps_ff, ps_in, pc_ff, pc_in;
   logic signed [PROD_W-1:0] mul_ff, mul_in, acc_ff, acc_in;
   logic signed [PT_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [PT_W-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   rsp_word_type             res_ff, res_in;
   rsp_word_type             out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;

   logic signed [PT_W-1:0]   mul_a;
   logic signed [TRIG_W-1:0] mul_b;
   logic signed [PT_W-1:0]   radius_s;
   logic [EDGE_W-1:0]        corner;
   logic                     last_pt;
   logic                     slot_free;
   logic signed [PROD_W-1:0] rnd_mul, rnd_sum;
   logic signed [SUM_W-1:0]  sum_x, sum_y, neg_cy;

   always_comb begin
      radius_s = $signed({2'b00, cmd_ff.radius});
      corner   = (k_ff == '0) ? cmd_ff.edge_count - 1'b1 : k_ff - 1'b1;
      last_pt  = (k_ff == cmd_ff.edge_count);
      slot_free = !out_valid_ff || pop;
      rnd_mul  = round_q15(mul_ff);
      rnd_sum  = round_q15(acc_ff + mul_ff);
      sum_x    = SUM_W'(cmd_ff.center_x) + SUM_W'(rx_ff);
      sum_y    = -(SUM_W'(cmd_ff.center_y) + SUM_W'(ry_ff));
      neg_cy   = -SUM_W'(cmd_data.center_y);

      // One shared multiplier; its operands follow the step.
      case (state_ff)
         B_M1:    begin mul_a = radius_s; mul_b = ps_ff; end
         B_M2:    begin mul_a = radius_s; mul_b = pc_ff; end
         B_M3:    begin mul_a = px_ff;    mul_b = sa_ff; end
         B_M4:    begin mul_a = py_ff;    mul_b = ca_ff; end
         B_M5:    begin mul_a = px_ff;    mul_b = ca_ff; end
         B_M6:    begin mul_a = py_ff;    mul_b = sa_ff; end
         default: begin mul_a = radius_s; mul_b = ps_ff; end
      endcase

      div_req.start = (state_ff == B_AS) || (state_ff == B_DS);
      if (state_ff == B_AS) begin
         div_req.num = {cmd_ff.angle_deg, PHASE_W'(0)} + DIV_NUM_W'(HALF_DEG_FULL);
         div_req.den = DEG_FULL;
      end else begin
         div_req.num = {1'b0, corner, 2'b01, PHASE_W'(0)} + DIV_NUM_W'({cmd_ff.edge_count, 1'b0});
         div_req.den = {1'b0, cmd_ff.edge_count, 2'b00};
      end
      trig_req.start = div_rsp.done && ((state_ff == B_DANG) || (state_ff == B_DV));
      trig_req.phase = div_rsp.quot;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      k_in         = k_ff;
      sa_in        = sa_ff;
      ca_in        = ca_ff;
      ps_in        = ps_ff;
      pc_in        = pc_ff;
      mul_in       = $signed(PROD_W'(mul_a)) * $signed(PROD_W'(mul_b));
      acc_in       = acc_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      cmd_pop      = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_data;
               if (cmd_data.is_circle) begin
                  res_in.point_kind     = KIND_ELLIPSE;
                  res_in.point_x        = cmd_data.center_x;
                  res_in.point_y        = sat_coord(neg_cy);
                  res_in.ellipse_radius = cmd_data.radius;
                  res_in.last           = 1'b1;
                  state_in = B_OUT;
               end else begin
                  state_in = B_AS;
               end
            end
         end
         B_AS: begin
            state_in = B_DANG;
         end
         B_DANG: begin
            if (div_rsp.done) begin
               state_in = B_TANG;
            end
         end
         B_TANG: begin
            if (trig_rsp.done) begin
               sa_in    = trig_rsp.sin_val;
               ca_in    = trig_rsp.cos_val;
               k_in     = '0;
               state_in = B_DS;
            end
         end
         B_DS: begin
            state_in = B_DV;
         end
         B_DV: begin
            if (div_rsp.done) begin
               state_in = B_TV;
            end
         end
         B_TV: begin
            if (trig_rsp.done) begin
               ps_in    = trig_rsp.sin_val;
               pc_in    = trig_rsp.cos_val;
               state_in = B_M1;
            end
         end
         B_M1: begin
            state_in = B_M2;
         end
         B_M2: begin
            px_in    = rnd_mul[PT_W-1:0];
            state_in = B_M3;
         end
         B_M3: begin
            py_in    = rnd_mul[PT_W-1:0];
            state_in = B_M4;
         end
         B_M4: begin
            acc_in   = mul_ff;
            state_in = B_M5;
         end
         B_M5: begin
            rx_in    = rnd_sum[PT_W-1:0];
            state_in = B_M6;
         end
         B_M6: begin
            acc_in   = -mul_ff;
            state_in = B_M7;
         end
         B_M7: begin
            ry_in    = rnd_sum[PT_W-1:0];
            state_in = B_FIN;
         end
         B_FIN: begin
            res_in.point_kind     = (k_ff == '0) ? KIND_MOVE : KIND_LINE;
            res_in.point_x        = sat_coord(sum_x);
            res_in.point_y        = sat_coord(sum_y);
            res_in.ellipse_radius = '0;
            res_in.last           = last_pt;
            state_in = B_OUT;
         end
         B_OUT: begin
            if (slot_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               if (cmd_ff.is_circle || last_pt) begin
                  state_in = B_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = B_DS;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      k_ff   <= k_in;
      sa_ff  <= sa_in;
      ca_ff  <= ca_in;
      ps_ff  <= ps_in;
      pc_ff  <= pc_in;
      mul_ff <= mul_in;
      acc_ff <= acc_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      res_ff <= res_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: sv/regular_polygon_vertex_generator_unit.sv
// ---------------------------------------------------------------------------
// Regular polygon vertex generator: a circle gives one word from the queue head.
// Polygon: first the rotation sine, then N+1 path points, each set by a pass through
// the bit-serial phase divider and the sine unit.
// Synchronous active-high reset empties both queues and idles all sequencers.
// ---------------------------------------------------------------------------
module regular_polygon_vertex_generator_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  rpvg_pkg::req_word_type  req_data,
   output logic                   empty,
   input  logic                   pop,
   output rpvg_pkg::rsp_word_type  rsp_data
);
   import rpvg_pkg::*;

   // The front cleans each figure (edge count clamped to 3..63, angle folded
   // below 360) and holds up to four of them, so the producer can keep
   // pushing while the back is busy on a long polygon.
   logic          cmd_valid;
   logic          cmd_pop;
   req_word_type  cmd_data;
   div_req_type   div_req;
   div_rsp_type   div_rsp;
   trig_req_type  trig_req;
   trig_rsp_type  trig_rsp;

   rpvg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   // The divider turns a corner index into a 32-bit turn fraction, and the
   // rotation angle into one as well, each rounded to nearest.
   rpvg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // The sine unit folds the phase into one octant and evaluates the nested
   // Taylor polynomials in Q30, one multiplication per cycle.
   rpvg_trig u_trig (
      .clock    (clock),
      .reset    (reset),
      .trig_req (trig_req),
      .trig_rsp (trig_rsp)
   );

   // The back sequencer scales by the radius, rotates, adds the center,
   // negates Y and saturates. Its output register lets the next point be
   // computed while the current word waits to be popped.
   rpvg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .trig_req  (trig_req),
      .trig_rsp  (trig_rsp),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

`include "regular_polygon_vertex_generator_unit_assert.svh"

   // An ellipse word always closes its figure.
   `RPVG_ASSERT_SAME(a_ellipse_is_last, clock, reset, !empty && rsp_data.point_kind == KIND_ELLIPSE, rsp_data.last, "ellipse word without last")

   // Path points never carry a radius.
   `RPVG_ASSERT_SAME(a_path_no_radius, clock, reset, !empty && rsp_data.point_kind != KIND_ELLIPSE, rsp_data.ellipse_radius == '0, "path point with nonzero radius")

   // The back only takes a figure that the queue really holds.
   `RPVG_ASSERT_SAME(a_pop_has_cmd, clock, reset, cmd_pop, cmd_valid, "command popped from empty queue")

   // The sine unit never reports a result in the cycle right after a start.
   `RPVG_ASSERT_NEXT(a_trig_after_div, clock, reset, trig_req.start, !trig_rsp.done, "sine unit done too early")

endmodule

// File: verif/regular_polygon_vertex_generator_unit_tb.sv
// ---------------------------------------------------------------------------
// Regular polygon vertex generator testbench
// Sends circle and polygon figures through the request queue and checks every
// response word against a built-in predictor of the fixed-point geometry or
// a typed answer. A directed table covers extremes and clamping cases, then
// random figures follow. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module regular_polygon_vertex_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rpvg_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int RANDOM_FIGURES = 295;

   logic         clock;
   logic         reset;
   logic         push;
   logic         full;
   req_word_type req_data;
   logic         empty;
   logic         pop;
   rsp_word_type rsp_data;

   regular_polygon_vertex_generator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // Words still owed by the block, oldest first.
   rsp_word_type pending_points[$];
   int  error_count   = 0;
   int  words_checked = 0;
   int  figures_sent  = 0;
   int  idle_cycles   = 0;
   bit  sender_calm   = 0;
   bit  receiver_calm = 0;
   int  stall_left    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -----------------------------------------------------------------------
   // Predictor of the fixed-point geometry.
   // -----------------------------------------------------------------------
   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned PI_Q30X = 64'd3373259426;

   function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
      if (v > 64'sd8388607) begin
         return 24'sd8388607;
      end else if (v < -64'sd8388608) begin
         return -24'sd8388608;
      end
      return v[COORD_W-1:0];
   endfunction

   // Divide by 2^15, round to nearest with ties away from zero.
   function automatic longint scale_q15(input longint v);
      longint unsigned mag;
      longint unsigned q;
      mag = (v < 0) ? longint'(-v) : v;
      q = (mag + 64'd16384) >> 15;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint round_q30_to_q15(input longint unsigned v);
      longint unsigned r;
      r = (v + 64'd16384) >> 15;
      return (r > 64'd32767) ? 64'sd32767 : longint'(r);
   endfunction

   // Taylor series on one octant; w is in [0, 2^29].
   function automatic void octant_series(input longint unsigned w,
                                         output longint unsigned sv,
                                         output longint unsigned cv);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      x  = (w * PI_Q30X + Q30_ONE) >> 31;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      sv = (x * t) >> 30;
      t  = Q30_ONE - x2 / 56;
      t  = Q30_ONE - ((x2 * t) >> 30) / 30;
      t  = Q30_ONE - ((x2 * t) >> 30) / 12;
      cv = Q30_ONE - ((x2 * t) >> 30) / 2;
   endfunction

   // Sine and cosine in Q1.15 of a 32-bit turn fraction.
   function automatic void turn_sin_cos(input logic [31:0] phase,
                                        output longint s, output longint c);
      longint unsigned w;
      longint unsigned ps;
      longint unsigned pc;
      longint sa;
      longint ca;
      w = phase[29:0];
      if (w < 64'd536870912) begin
         octant_series(w, ps, pc);
         sa = round_q30_to_q15(ps);
         ca = round_q30_to_q15(pc);
      end else begin
         octant_series(64'd1073741824 - w, ps, pc);
         sa = round_q30_to_q15(pc);
         ca = round_q30_to_q15(ps);
      end
      case (phase[31:30])
         2'd0:    begin s = sa;  c = ca;  end
         2'd1:    begin s = ca;  c = -sa; end
         2'd2:    begin s = -sa; c = -ca; end
         default: begin s = -ca; c = sa;  end
      endcase
   endfunction

   // Queues every word that one figure produces.
   function automatic void predict_figure(input req_word_type f);
      rsp_word_type    pt;
      longint unsigned n;
      longint unsigned ang;
      longint unsigned corner;
      longint unsigned num;
      longint unsigned rad;
      longint sa, ca, ps, pc, px, py, rx, ry, cx, cy;
      rad = f.radius;
      cx  = f.center_x;
      cy  = f.center_y;
      if (f.is_circle) begin
         pt.point_kind     = KIND_ELLIPSE;
         pt.point_x        = clamp_coord(cx);
         pt.point_y        = clamp_coord(-cy);
         pt.ellipse_radius = f.radius;
         pt.last           = 1'b1;
         pending_points.push_back(pt);
         return;
      end
      n = f.edge_count;
      if (n < MIN_EDGES) n = MIN_EDGES;
      if (n > MAX_EDGES) n = MAX_EDGES;
      ang = f.angle_deg % 360;
      turn_sin_cos(32'(((ang << 32) + 64'd180) / 64'd360), sa, ca);
      for (longint unsigned k = 0; k <= n; k++) begin
         corner = (k == 0) ? n - 1 : k - 1;
         num = ((64'd1 + 4 * corner) << 32) + 2 * n;
         turn_sin_cos(32'(num / (4 * n)), ps, pc);
         px = scale_q15(longint'(rad) * ps);
         py = scale_q15(longint'(rad) * pc);
         rx = scale_q15(px * sa + py * ca);
         ry = scale_q15(-px * ca + py * sa);
         pt.point_kind     = (k == 0) ? KIND_MOVE : KIND_LINE;
         pt.point_x        = clamp_coord(cx + rx);
         pt.point_y        = clamp_coord(-(cy + ry));
         pt.ellipse_radius = '0;
         pt.last           = (k == n);
         pending_points.push_back(pt);
      end
   endfunction

   // -----------------------------------------------------------------------
   // Response side: stalls at random, compares each popped word with the
   // oldest expectation, field by field.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      int stall;
      if (reset) begin
         pop <= 1'b0;
         stall_left <= 0;
      end else if (pop && !empty) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected word, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            words_checked++;
            if (rsp_data.point_kind !== want.point_kind ||
                rsp_data.point_x !== want.point_x ||
                rsp_data.point_y !== want.point_y ||
                rsp_data.ellipse_radius !== want.ellipse_radius ||
                rsp_data.last !== want.last) begin
               $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp_data);
               error_count++;
            end
         end
         stall = receiver_calm ? 0 : $urandom_range(0, 10);
         if (stall == 0) begin
            pop <= 1'b1;
         end else begin
            pop <= 1'b0;
            stall_left <= stall - 1;
         end
      end else if (!pop) begin
         if (stall_left == 0) begin
            pop <= 1'b1;
         end else begin
            stall_left <= stall_left - 1;
         end
      end
   end

   // Watchdog: counts cycles in which neither side moves a word.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d words owed", $time,
                     pending_points.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Presents one figure after a random gap and returns once it is taken.
   task automatic send_figure(input req_word_type f);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= f;
      do @(posedge clock); while (full);
      figures_sent++;
   endtask

   function automatic req_word_type make_figure(input bit circ, input int n,
                                                input int r, input int cx,
                                                input int cy, input int ang);
      req_word_type f;
      f.is_circle  = circ;
      f.edge_count = n[EDGE_W-1:0];
      f.radius     = r[RADIUS_W-1:0];
      f.center_x   = cx[COORD_W-1:0];
      f.center_y   = cy[COORD_W-1:0];
      f.angle_deg  = ang[ANGLE_W-1:0];
      return f;
   endfunction

   typedef struct {
      req_word_type figure;
      bit           typed;
      rsp_word_type answer;
   } table_row_type;

   table_row_type directed_rows[$];

   initial begin
      req_word_type fig;
      table_row_type row;
      int mode;

      reset    <= 1'b1;
      push     <= 1'b0;
      req_data <= '0;

      // Circles carry their expected word directly: center with Y negated.
      row.typed = 1;
      row.figure = make_figure(1, 0, 0, 0, 0, 0);
      row.answer = '{KIND_ELLIPSE, 24'sd0, 24'sd0, 23'd0, 1'b1};
      directed_rows.push_back(row);
      // Negating the most negative Y clamps to the positive limit.
      row.figure = make_figure(1, 63, 8388607, 8388607, -8388608, 511);
      row.answer = '{KIND_ELLIPSE, 24'sd8388607, 24'sd8388607, 23'd8388607, 1'b1};
      directed_rows.push_back(row);
      row.figure = make_figure(1, 0, 1, -8388608, 8388607, 359);
      row.answer = '{KIND_ELLIPSE, -24'sd8388608, -24'sd8388607, 23'd1, 1'b1};
      directed_rows.push_back(row);
      row.figure = make_figure(1, 5, 256, 1280, -2560, 45);
      row.answer = '{KIND_ELLIPSE, 24'sd1280, 24'sd2560, 23'd256, 1'b1};
      directed_rows.push_back(row);

      // Polygons go through the predictor.
      row.typed = 0;
      row.answer = '0;
      row.figure = make_figure(0, 0, 2560, 0, 0, 0);            // N=0 taken as 3
      directed_rows.push_back(row);
      row.figure = make_figure(0, 1, 2560, 100, -100, 90);      // N=1 taken as 3
      directed_rows.push_back(row);
      row.figure = make_figure(0, 2, 0, 0, 0, 180);             // zero radius
      directed_rows.push_back(row);
      row.figure = make_figure(0, 3, 8388607, 0, 0, 270);       // largest radius
      directed_rows.push_back(row);
      row.figure = make_figure(0, 4, 25600, 0, 0, 359);
      directed_rows.push_back(row);
      row.figure = make_figure(0, 6, 25600, 0, 0, 360);         // wraps to 0
      directed_rows.push_back(row);
      row.figure = make_figure(0, 5, 25600, 0, 0, 511);         // wraps to 151
      directed_rows.push_back(row);
      row.figure = make_figure(0, 63, 65536, -5000, 7000, 17);  // most edges
      directed_rows.push_back(row);
      row.figure = make_figure(0, 8, 8388607, 8388607, -8388608, 33); // clamps
      directed_rows.push_back(row);
      row.figure = make_figure(0, 7, 8388607, -8388608, 8388607, 201);
      directed_rows.push_back(row);
      row.figure = make_figure(0, 3, 1, 8388607, 8388607, 1);
      directed_rows.push_back(row);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_figure(directed_rows[i].figure);
         if (directed_rows[i].typed) begin
            pending_points.push_back(directed_rows[i].answer);
         end else begin
            predict_figure(directed_rows[i].figure);
         end
      end

      for (int i = 0; i < RANDOM_FIGURES; i++) begin
         // Runs of back-to-back traffic alternate with random idling.
         if (i % 40 == 0) begin
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
         end
         // Once midway the sender waits until every owed word has drained.
         if (i == RANDOM_FIGURES / 2) begin
            push <= 1'b0;
            while (pending_points.size() != 0) @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         fig.is_circle  = ($urandom_range(0, 3) == 0);
         mode = $urandom_range(0, 9);
         fig.edge_count = (mode == 0) ? EDGE_W'($urandom) : EDGE_W'($urandom_range(0, 10));
         fig.radius     = (mode < 5) ? RADIUS_W'($urandom_range(0, 65535))
                                     : RADIUS_W'($urandom);
         fig.center_x   = COORD_W'($urandom);
         fig.center_y   = COORD_W'($urandom);
         fig.angle_deg  = ANGLE_W'($urandom);
         send_figure(fig);
         predict_figure(fig);
      end
      push <= 1'b0;

      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d figures (circles and polygons of 3 to 63 edges),", figures_sent);
      $display("checked %0d words with random gaps and stalls on both sides.", words_checked);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
